// File: rtl/rrmtf_pkg.sv
`default_nettype none

package rrmtf_pkg;

	// Capacity of the ordered list, the widths that follow from it and the id width.
	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = $clog2(DEPTH + 1);
	localparam int ID_W   = 30;

	// Function codes of a request.
	localparam logic FUNC_SERVE    = 1'b0;
	localparam logic FUNC_EXPEDITE = 1'b1;

	// One request item.
	typedef struct packed {
		logic            func;
		logic [ID_W-1:0] member_id;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [ID_W-1:0] served_id;
		logic            dropped_tail;
	} res_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SERVE,
		ST_WALK,
		ST_TAIL
	} state_t;

endpackage

`default_nettype wire

// File: rtl/round_robin_queue_move_to_front.sv
// Move-to-front round-robin service queue over member ids.
//
// Requests arrive on the req channel (req_valid, req_stall, req). A serve
// request returns the id at the head of the list on the res channel and
// rotates it to the tail; an expedite request moves member_id to the head,
// inserting it if absent, and returns nothing. The population register is
// written on the cfg channel (cfg_valid, cfg_ready, cfg_data).
//
// The list lives in one simple dual-port memory used as a circular buffer.
// A serve reads the head entry, writes it past the tail in ST_SERVE and loads
// the result register there. An expedite walks the list from the head until
// the id is found or the tail is reached; the walk reads one entry and writes
// one entry a cycle. One request is in flight at a time.
//
// After reset, and after every population write, the block fills all DEPTH
// memory entries with ids one upward, one entry a cycle; req_stall stays
// high during that fill. A result waits in an output register while
// res_stall is high, and no new request is taken until that slot is free.
`default_nettype none

module round_robin_queue_move_to_front
	import rrmtf_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire req_t            req,
	output logic                 res_valid,
	input  wire logic            res_stall,
	output res_t                 res,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [ID_W-1:0] cfg_data
);

	localparam logic [LEN_W:0]    DEPTH_X  = (LEN_W + 1)'(DEPTH);
	localparam logic [LEN_W-1:0]  DEPTH_L  = LEN_W'(DEPTH);
	localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(DEPTH - 1);
	localparam logic [ID_W-1:0]   DEPTH_ID = ID_W'(DEPTH);

	// Circular address: a + b modulo DEPTH, with a below DEPTH and b at most DEPTH.
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
	                                               input logic [LEN_W-1:0] b);
		logic [LEN_W:0] s;
		s = (LEN_W + 1)'(a) + {1'b0, b};
		if (s >= DEPTH_X) begin
			s = s - DEPTH_X;
		end
		return s[ADDR_W-1:0];
	endfunction

	state_t state_q, state_d;

	logic [ADDR_W-1:0] head_q;
	logic [LEN_W-1:0]  len_q;
	logic              overflow_q;
	logic [ADDR_W-1:0] init_q;
	logic [ADDR_W-1:0] wk_q;
	logic [ID_W-1:0]   id_q;
	logic [ID_W-1:0]   carry_q;
	logic              res_valid_q;
	res_t              res_q;

	// Memory ports.
	logic [ID_W-1:0]   mem [DEPTH];
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [ID_W-1:0]   wdata;
	logic              we;
	logic [ID_W-1:0]   rdata_s1;

	logic              req_xfer;
	logic              cfg_xfer;
	logic              found;
	logic              walk_last;
	logic [LEN_W-1:0]  wk_next;
	logic [LEN_W-1:0]  cfg_len;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid;
	assign req_stall = !((state_q == ST_IDLE) && (!res_valid_q || !res_stall));
	assign req_xfer  = req_valid && !req_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign wk_next   = LEN_W'(wk_q) + LEN_W'(1);
	assign found     = (rdata_s1 == id_q);
	assign walk_last = (wk_next == len_q);
	assign cfg_len   = (cfg_data > DEPTH_ID) ? DEPTH_L : cfg_data[LEN_W-1:0];

	// List memory: at most one write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (init_q == LAST_A) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_xfer) begin
					if (req.func == FUNC_SERVE) begin
						if (len_q != '0) begin
							state_d = ST_SERVE;
						end
					end else if (len_q == '0) begin
						state_d = ST_TAIL;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_SERVE: state_d = ST_IDLE;
			ST_WALK: begin
				if (found) begin
					state_d = ST_IDLE;
				end else if (walk_last) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (cfg_xfer) begin
			state_d = ST_INIT;
		end
	end

	// Memory control.
	always_comb begin
		we    = 1'b0;
		waddr = head_q;
		wdata = carry_q;
		raddr = head_q;
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = init_q;
				wdata = ID_W'(init_q) + ID_W'(1);
			end
			ST_IDLE: begin
				raddr = head_q;
			end
			ST_SERVE: begin
				// The head entry goes to the slot just past the tail.
				we    = 1'b1;
				waddr = wrap_add(head_q, len_q);
				wdata = rdata_s1;
			end
			ST_WALK: begin
				// Shift each entry up by one while looking ahead at the next.
				we    = 1'b1;
				waddr = wrap_add(head_q, LEN_W'(wk_q));
				wdata = carry_q;
				raddr = wrap_add(head_q, wk_next);
			end
			ST_TAIL: begin
				we    = (len_q != DEPTH_L);
				waddr = wrap_add(head_q, len_q);
				wdata = carry_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Control and list bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			head_q      <= '0;
			len_q       <= LEN_W'(1);
			overflow_q  <= 1'b0;
			init_q      <= '0;
			wk_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_xfer) begin
				head_q     <= '0;
				len_q      <= cfg_len;
				overflow_q <= 1'b0;
				init_q     <= '0;
			end else begin
				case (state_q)
					ST_INIT: init_q <= init_q + ADDR_W'(1);
					ST_IDLE: wk_q <= '0;
					ST_SERVE: begin
						head_q      <= wrap_add(head_q, LEN_W'(1));
						res_valid_q <= 1'b1;
					end
					ST_WALK: wk_q <= wk_q + ADDR_W'(1);
					ST_TAIL: begin
						// A full list loses its tail; otherwise it grows by one.
						if (len_q != DEPTH_L) begin
							len_q <= len_q + LEN_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
					end
					default: wk_q <= wk_q;
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			id_q    <= req.member_id;
			carry_q <= req.member_id;
		end else if (state_q == ST_WALK) begin
			carry_q <= rdata_s1;
		end
		if (state_q == ST_SERVE) begin
			res_q.served_id    <= rdata_s1;
			res_q.dropped_tail <= overflow_q;
		end
	end

endmodule

`default_nettype wire

// File: verif/round_robin_queue_move_to_front_tb.sv
`timescale 1ns / 1ps

module round_robin_queue_move_to_front_tb;
	import rrmtf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = DEPTH + 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 46;
	localparam int PLAN_ROWS      = 32;
	localparam logic [ID_W-1:0] ID_MAX = '1;

	typedef enum logic {ROW_CFG, ROW_REQ} row_op_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_RESULT, CHK_NONE} row_chk_t;

	typedef struct packed {
		row_op_t         op;
		row_chk_t        chk;
		logic            func;
		logic [ID_W-1:0] value;
		res_t            want;
	} row_t;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	req_t            req       = '0;
	logic            res_valid;
	logic            res_stall = 1'b0;
	res_t            res;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [ID_W-1:0] cfg_data  = '0;

	// Predicted list order, overflow flag and the results still owed.
	logic [ID_W-1:0] roster[$];
	logic            overflow_flag;
	res_t            expected_results[$];

	int mismatches     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int holds_done     = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	// Directed rows: population writes and requests, some with the result typed in.
	row_t plan [0:PLAN_ROWS-1] = '{
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{30'd1, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'd0,         '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, ID_MAX,        '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{ID_MAX, 1'b0}},
		'{ROW_CFG, CHK_NONE,   FUNC_SERVE,    30'd0,         '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_SERVE,    ID_MAX,        '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'd5,         '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{30'd5, 1'b0}},
		'{ROW_CFG, CHK_NONE,   FUNC_SERVE,    30'd3,         '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'd3,         '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'd3,         '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{30'd3, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'd2,         '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{30'd2, 1'b0}},
		'{ROW_CFG, CHK_NONE,   FUNC_SERVE,    30'd1024,      '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'd1024,      '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{30'd1024, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'd2000,      '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{30'd2000, 1'b1}},
		'{ROW_CFG, CHK_NONE,   FUNC_SERVE,    ID_MAX,        '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{30'd1, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'h2AAAAAAA,  '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_MODEL,  FUNC_SERVE,    30'h15555555,  '{30'd0, 1'b0}},
		'{ROW_CFG, CHK_NONE,   FUNC_SERVE,    30'd1025,      '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{30'd1, 1'b0}},
		'{ROW_CFG, CHK_NONE,   FUNC_SERVE,    30'd1023,      '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'd1,         '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'd5000,      '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_NONE,   FUNC_EXPEDITE, 30'd5001,      '{30'd0, 1'b0}},
		'{ROW_REQ, CHK_RESULT, FUNC_SERVE,    30'd0,         '{30'd5001, 1'b1}},
		'{ROW_REQ, CHK_MODEL,  FUNC_SERVE,    30'd0,         '{30'd0, 1'b0}}
	};

	// Population of each random phase; the last one is drawn at run time.
	logic [ID_W-1:0] phase_population [0:PHASES-1] = '{
		30'd4, 30'd1, 30'd0, 30'd2, 30'd6, 30'd8,
		30'd1024, 30'd3, ID_MAX, 30'd16, 30'd1023, 30'd1
	};

	round_robin_queue_move_to_front i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Rebuild the predicted list as the block does after reset or a population write.
	function automatic void rebuild_roster(input logic [ID_W-1:0] population);
		int count;
		count = (population > ID_W'(DEPTH)) ? DEPTH : int'(population);
		roster.delete();
		for (int i = 1; i <= count; i++)
			roster.insert(roster.size(), ID_W'(i));
		overflow_flag = 1'b0;
	endfunction

	// Apply one request to the predicted list; returns 1 when it serves an id.
	function automatic bit apply_request(input req_t r, output res_t served);
		logic [ID_W-1:0] head;
		int pos;
		served = '0;
		if (r.func == FUNC_SERVE) begin
			if (roster.size() == 0)
				return 1'b0;
			head = roster[0];
			roster.delete(0);
			roster.insert(roster.size(), head);
			served.served_id = head;
			served.dropped_tail = overflow_flag;
			return 1'b1;
		end
		// Expedite: pull the id out if present, else make room for it.
		pos = -1;
		foreach (roster[i])
			if (pos < 0 && roster[i] == r.member_id)
				pos = i;
		if (pos >= 0) begin
			roster.delete(pos);
		end else if (roster.size() >= DEPTH) begin
			void'(roster.pop_back());
			overflow_flag = 1'b1;
		end
		roster.insert(0, r.member_id);
		return 1'b0;
	endfunction

	// Offer one request until its transfer, then record the result it owes.
	task automatic send_request(input req_t r, input row_chk_t chk, input res_t want);
		res_t served;
		bit yields;
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		yields = apply_request(r, served);
		if (chk == CHK_RESULT)
			expected_results.insert(expected_results.size(), want);
		else if (chk == CHK_MODEL && yields)
			expected_results.insert(expected_results.size(), served);
		// Optional idle gap before the next request.
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Write the population once the block has drained and finished any walk.
	task automatic write_population(input logic [ID_W-1:0] population);
		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data <= population;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		rebuild_roster(population);
	endtask

	// Result side: random stall, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_requests != holds_done) begin
			holds_done = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Compare each result transfer with the oldest expectation; watch for a hang.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected: served_id=%0d dropped_tail=%0b",
						$time, res.served_id, res.dropped_tail);
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (res.served_id !== want.served_id) begin
						mismatches++;
						$display("%0t: served_id expected %0d, actual %0d",
							$time, want.served_id, res.served_id);
					end
					if (res.dropped_tail !== want.dropped_tail) begin
						mismatches++;
						$display("%0t: dropped_tail expected %0b, actual %0b",
							$time, want.dropped_tail, res.dropped_tail);
					end
				end
			end
			if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Reset, directed rows, random phases, then drain and report.
	initial begin : stimulus
		req_t item;
		logic [ID_W-1:0] population;
		int roll;
		int mode;
		rebuild_roster(ID_W'(1));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int n = 0; n < PLAN_ROWS; n++) begin
			if (plan[n].op == ROW_CFG) begin
				write_population(plan[n].value);
			end else begin
				item.func = plan[n].func;
				item.member_id = plan[n].value;
				send_request(item, plan[n].chk, plan[n].want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			population = phase_population[phase];
			if (phase == PHASES - 1)
				population = ID_W'($urandom_range(12, 1));
			write_population(population);
			mode = phase % 4;
			send_idle_pct = (mode == 1) ? 57 : (mode == 3) ? 29 : 0;
			recv_stall_pct = (mode == 2) ? 57 : (mode == 3) ? 29 : 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// One long hold-off on the result side while requests keep coming.
				if (phase == 4 && k == 10)
					hold_requests++;
				item.func = ($urandom_range(99) < 55) ? FUNC_SERVE : FUNC_EXPEDITE;
				roll = $urandom_range(99);
				if (roll < 40 && roster.size() != 0)
					item.member_id = roster[$urandom_range(roster.size() - 1)];
				else if (roll < 65)
					item.member_id = ID_W'($urandom_range(roster.size() + 2));
				else if (roll < 85)
					item.member_id = ID_W'(2000 + $urandom_range(7));
				else
					item.member_id = ID_W'($urandom());
				send_request(item, CHK_MODEL, '0);
			end
		end

		req_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
